>>> hdl/mdio_mm_pkg.sv
// ----------------------------------------------------------------------------
// mdio_mm_pkg
// Shared types and constants for the MII management (clause 22) master.
// ----------------------------------------------------------------------------
`default_nettype none

package mdio_mm_pkg;

	localparam int unsigned CNT_W        = 7;
	localparam int unsigned CMD_BITS     = 16;
	localparam int unsigned DATA_BITS    = 16;
	localparam int unsigned WR_IDLE_CLKS = 2;

	// command word templates: start, opcode and turnaround bits
	localparam logic [15:0] CMD_READ  = 16'h6000;
	localparam logic [15:0] CMD_WRITE = 16'h5002;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic        start_req;
		logic        operation;
		logic [4:0]  phy_addr;
		logic [4:0]  reg_addr;
		logic [15:0] write_data;
		logic        mdio_in;
	} tick_t;

	typedef struct packed {
		logic        mdc;
		logic        mdio_out;
		logic        mdio_oe;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_data;
	} pins_t;

endpackage

`default_nettype wire

>>> hdl/mdio_mm_frame.sv
// ----------------------------------------------------------------------------
// mdio_mm_frame
// Frame sequencer: access state, bit counter, clock phase and shifter.
// Computes one tick's pin levels and advances the state when step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mdio_mm_frame #(
	parameter int unsigned PREAMBLE_BITS = 32
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   step,
	input  wire mdio_mm_pkg::tick_t tick,
	output mdio_mm_pkg::pins_t    pins
);

	localparam logic [mdio_mm_pkg::CNT_W-1:0] PRE_END =
		mdio_mm_pkg::CNT_W'(PREAMBLE_BITS);
	localparam logic [mdio_mm_pkg::CNT_W-1:0] CMD_END =
		mdio_mm_pkg::CNT_W'(PREAMBLE_BITS + mdio_mm_pkg::CMD_BITS);
	localparam logic [mdio_mm_pkg::CNT_W-1:0] DATA_END =
		mdio_mm_pkg::CNT_W'(PREAMBLE_BITS + mdio_mm_pkg::CMD_BITS + mdio_mm_pkg::DATA_BITS);
	localparam logic [mdio_mm_pkg::CNT_W-1:0] WR_END =
		mdio_mm_pkg::CNT_W'(PREAMBLE_BITS + mdio_mm_pkg::CMD_BITS + mdio_mm_pkg::DATA_BITS
			+ mdio_mm_pkg::WR_IDLE_CLKS);

	logic                            active_q;
	logic                            is_write_q;
	logic [mdio_mm_pkg::CNT_W-1:0]   cnt_q;
	logic                            high_q;
	logic [31:0]                     frame_q;
	logic [15:0]                     cap_q;

	logic                            start;
	logic                            act;
	logic                            iw;
	logic [31:0]                     fs;
	logic [mdio_mm_pkg::CNT_W-1:0]   n;
	logic                            high;
	logic [15:0]                     cmd;
	logic [mdio_mm_pkg::CNT_W-1:0]   end_cnt;

	logic                            active_d;
	logic [mdio_mm_pkg::CNT_W-1:0]   cnt_d;
	logic                            high_d;
	logic [31:0]                     frame_d;
	logic [15:0]                     cap_d;

	always_comb begin
		start = !active_q && tick.start_req;
		act   = active_q || tick.start_req;
		iw    = start ? tick.operation : is_write_q;
		cmd   = (tick.operation == mdio_mm_pkg::OP_WRITE ? mdio_mm_pkg::CMD_WRITE
			: mdio_mm_pkg::CMD_READ) | {4'b0, tick.phy_addr, tick.reg_addr, 2'b0};
		fs    = start ? {cmd, (tick.operation == mdio_mm_pkg::OP_WRITE)
			? tick.write_data : 16'h0} : frame_q;
		n     = start ? '0 : cnt_q;
		high  = start ? 1'b0 : high_q;
		end_cnt = iw ? WR_END : DATA_END;

		pins          = '0;
		active_d      = active_q;
		cnt_d         = cnt_q;
		high_d        = high_q;
		frame_d       = fs;
		cap_d         = cap_q;

		if (act) begin
			active_d = 1'b1;
			if (n >= end_cnt) begin
				pins.done_res = 1'b1;
				if (!iw)
					cap_d = fs[15:0];
				active_d = 1'b0;
				cnt_d    = '0;
				high_d   = 1'b0;
			end else begin
				pins.busy_res = 1'b1;
				pins.mdc      = high;
				if (n < PRE_END) begin
					pins.mdio_out = 1'b1;
					pins.mdio_oe  = 1'b1;
				end else if (n < CMD_END || (iw && n < DATA_END)) begin
					pins.mdio_out = fs[31];
					pins.mdio_oe  = 1'b1;
					if (high)
						frame_d = {fs[30:0], 1'b0};
				end else if (!iw && !high) begin
					// read data phase: line released, sample on the low half
					frame_d = {fs[30:0], tick.mdio_in};
				end
				if (high) begin
					cnt_d  = n + 1'b1;
					high_d = 1'b0;
				end else begin
					cnt_d  = n;
					high_d = 1'b1;
				end
			end
		end
		pins.read_data = cap_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			is_write_q <= 1'b0;
			cnt_q      <= '0;
			high_q     <= 1'b0;
			frame_q    <= '0;
			cap_q      <= '0;
		end else if (step) begin
			active_q   <= active_d;
			is_write_q <= iw;
			cnt_q      <= cnt_d;
			high_q     <= high_d;
			frame_q    <= frame_d;
			cap_q      <= cap_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/mdio_management_master.sv
// An accepted tick reaches its result through the input register and then the result register.
// Throughput: one tick per cycle while out_stall is low; the frame sequencer advances once per accepted tick.
// The input register holds at most one tick while a result waits on out_stall.
// Reset (arst_n low, asynchronous): idle, counters, shifter and captured read data cleared,
// both channels empty.
// ----------------------------------------------------------------------------
// mdio_management_master
// MII management master, one half MDC period per input item.
// ----------------------------------------------------------------------------
`default_nettype none

module mdio_management_master #(
	parameter int unsigned PREAMBLE_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,

	input  wire         in_valid,
	output logic        in_stall,
	input  wire         start_req,
	input  wire         operation,
	input  wire  [4:0]  phy_addr,
	input  wire  [4:0]  reg_addr,
	input  wire  [15:0] write_data,
	input  wire         mdio_in,

	output logic        out_valid,
	input  wire         out_stall,
	output logic        mdc,
	output logic        mdio_out,
	output logic        mdio_oe,
	output logic        busy_res,
	output logic        done_res,
	output logic [15:0] read_data
);

	logic                 valid_s1;
	mdio_mm_pkg::tick_t   tick_s1;
	logic                 valid_s2;
	mdio_mm_pkg::pins_t   pins_s2;
	mdio_mm_pkg::pins_t   pins;
	logic                 out_hold;
	logic                 adv_s1;
	logic                 in_take;

	assign out_hold = valid_s2 && out_stall;
	assign adv_s1   = valid_s1 && !out_hold;
	assign in_stall = valid_s1 && out_hold;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			tick_s1 <= '{start_req:  start_req,
			             operation:  operation,
			             phy_addr:   phy_addr,
			             reg_addr:   reg_addr,
			             write_data: write_data,
			             mdio_in:    mdio_in};
		end
	end

	mdio_mm_frame #(
		.PREAMBLE_BITS(PREAMBLE_BITS)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.tick   (tick_s1),
		.pins   (pins)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			pins_s2 <= pins;
	end

	assign out_valid = valid_s2;
	assign mdc       = pins_s2.mdc;
	assign mdio_out  = pins_s2.mdio_out;
	assign mdio_oe   = pins_s2.mdio_oe;
	assign busy_res  = pins_s2.busy_res;
	assign done_res  = pins_s2.done_res;
	assign read_data = pins_s2.read_data;

endmodule

`default_nettype wire
